// ===== hw/rtl/owbm_pkg.sv =====
// Shared types and constants for the 1-Wire bus master.
// No dependencies; imported by onewire_bus_master_unit, owbm_cfg, owbm_core and the testbench.
`default_nettype none
package owbm_pkg;

    // command codes carried by one input beat
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_RESET = 3'd1;
    localparam logic [2:0] CMD_WBYTE = 3'd2;
    localparam logic [2:0] CMD_RBYTE = 3'd3;
    localparam logic [2:0] CMD_WBIT  = 3'd4;
    localparam logic [2:0] CMD_RBIT  = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_LOW_PULSE = 3'd0;
    localparam logic [2:0] REG_SAMPLE_PT = 3'd1;
    localparam logic [2:0] REG_SLOT      = 3'd2;
    localparam logic [2:0] REG_RECOVERY  = 3'd3;
    localparam logic [2:0] REG_RESET_LOW = 3'd4;
    localparam logic [2:0] REG_PRES_SMP  = 3'd5;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned TMR_W      = 10;

    // ticks between presence samples
    localparam logic [TMR_W-1:0] PRESENCE_SPACING = 10'd8;

    // timing values after clamping to legal ranges
    typedef struct packed {
        logic [5:0]       low_pulse;
        logic [7:0]       slot;
        logic [7:0]       sample_pt;
        logic [5:0]       recovery;
        logic [TMR_W-1:0] reset_low;
        logic [6:0]       pres_smp;
    } t_timing;

    typedef struct packed {
        logic       drive_enable;
        logic       drive_level;
        logic       busy;
        logic       done;
        logic       presence;
        logic [7:0] read_data;
        logic       cmd_rejected;
    } t_res;

endpackage
`default_nettype wire

// ===== hw/rtl/onewire_bus_master_unit.sv =====
// Top level of the 1-Wire bus master: input register, config, sequencer.
// Depends on owbm_pkg, owbm_cfg and owbm_core.
//
//  channel | signals                                | direction
//  --------+----------------------------------------+----------
//  in      | i_in_valid/o_in_ready, cmd, data, line | into block
//  out     | o_out_valid/i_out_ready, result fields | out of block
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data        | into block
//
// One beat per clock sustained while the output is not stalled; an accepted beat passes
// through the input register, then the sequencer step into the result register.
// Stalls on the output hold the result and the input register; the input
// side keeps taking a beat as long as its register empties in the same cycle.
// Synchronous active-low reset clears the sequencer and both valid flags.
`default_nettype none
module onewire_bus_master_unit
    import owbm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [2:0]            i_cmd,
    input  wire logic [7:0]            i_data_in,
    input  wire logic                  i_line_level,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_drive_enable,
    output logic                       o_drive_level,
    output logic                       o_busy_res,
    output logic                       o_done_res,
    output logic                       o_presence,
    output logic [7:0]                 o_read_data,
    output logic                       o_cmd_rejected,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic       r_in_vld;
    logic [2:0] r_cmd;
    logic [7:0] r_din;
    logic       r_line;
    logic       r_out_vld;
    logic       step;
    t_timing    timing;
    t_res       res;

    // advance when the result slot is free or being drained
    assign step       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (step) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd  <= i_cmd;
            r_din  <= i_data_in;
            r_line <= i_line_level;
        end
    end

    owbm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_timing   (timing)
    );

    owbm_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_cmd        (r_cmd),
        .i_data_in    (r_din),
        .i_line_level (r_line),
        .i_timing     (timing),
        .o_res        (res)
    );

    assign o_out_valid    = r_out_vld;
    assign o_drive_enable = res.drive_enable;
    assign o_drive_level  = res.drive_level;
    assign o_busy_res     = res.busy;
    assign o_done_res     = res.done;
    assign o_presence     = res.presence;
    assign o_read_data    = res.read_data;
    assign o_cmd_rejected = res.cmd_rejected;

endmodule
`default_nettype wire

// ===== hw/rtl/owbm_cfg.sv =====
// Configuration registers of the 1-Wire bus master and their clamping.
// Depends on owbm_pkg.
`default_nettype none
module owbm_cfg
    import owbm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_timing                    o_timing
);

    logic [5:0]       r_low_pulse;
    logic [6:0]       r_sample_pt;
    logic [7:0]       r_slot;
    logic [5:0]       r_recovery;
    logic [TMR_W-1:0] r_reset_low;
    logic [6:0]       r_pres_smp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_pulse <= 6'd3;
            r_sample_pt <= 7'd12;
            r_slot      <= 8'd78;
            r_recovery  <= 6'd6;
            r_reset_low <= 10'd520;
            r_pres_smp  <= 7'd65;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LOW_PULSE: r_low_pulse <= i_cfg_data[5:0];
                REG_SAMPLE_PT: r_sample_pt <= i_cfg_data[6:0];
                REG_SLOT:      r_slot      <= i_cfg_data[7:0];
                REG_RECOVERY:  r_recovery  <= i_cfg_data[5:0];
                REG_RESET_LOW: r_reset_low <= i_cfg_data;
                REG_PRES_SMP:  r_pres_smp  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    logic [5:0] lp;
    logic [7:0] sl;
    logic [7:0] sp;

    always_comb begin
        lp = (r_low_pulse == 6'd0) ? 6'd1 : r_low_pulse;
        sl = (r_slot > {2'b00, lp}) ? r_slot : ({2'b00, lp} + 8'd1);
        sp = {1'b0, r_sample_pt};
        // keep the sample point inside the released part of the slot
        if (sp < {2'b00, lp}) begin
            sp = {2'b00, lp};
        end
        if (sp > (sl - 8'd1)) begin
            sp = sl - 8'd1;
        end
        o_timing.low_pulse = lp;
        o_timing.slot      = sl;
        o_timing.sample_pt = sp;
        o_timing.recovery  = r_recovery;
        o_timing.reset_low = (r_reset_low == '0) ? 10'd1 : r_reset_low;
        o_timing.pres_smp  = (r_pres_smp == 7'd0) ? 7'd1 : r_pres_smp;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/owbm_core.sv =====
// Bus timing sequencer: one tick per step, state plus the result register.
// Depends on owbm_pkg.
`default_nettype none
module owbm_core
    import owbm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [2:0] i_cmd,
    input  wire logic [7:0] i_data_in,
    input  wire logic       i_line_level,
    input  wire t_timing    i_timing,
    output t_res            o_res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_SLOT,
        PH_RECOV
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [2:0]       r_op, n_op;
    logic [TMR_W-1:0] r_tmr, n_tmr;
    logic [3:0]       r_bits, n_bits;
    logic [7:0]       r_shift, n_shift;
    logic [6:0]       r_samp, n_samp;
    logic             r_pres, n_pres;
    t_res             r_res, n_res;

    logic             is_cmd;
    logic             is_wr;
    logic             is_rd;
    logic [TMR_W-1:0] tmr_inc;

    always_comb begin
        n_phase = r_phase;
        n_op    = r_op;
        n_tmr   = r_tmr;
        n_bits  = r_bits;
        n_shift = r_shift;
        n_samp  = r_samp;
        n_pres  = r_pres;
        n_res   = '0;

        is_cmd = i_cmd inside {[CMD_RESET:CMD_RBIT]};

        if (r_phase != PH_IDLE) begin
            n_res.cmd_rejected = is_cmd;
        end else if (is_cmd) begin
            n_op  = i_cmd;
            n_tmr = '0;
            if (i_cmd == CMD_RESET) begin
                n_phase = PH_RST_LOW;
                n_pres  = 1'b0;
            end else begin
                n_phase = PH_SLOT;
                case (i_cmd)
                    CMD_WBYTE: begin n_shift = i_data_in; n_bits = 4'd8; end
                    CMD_WBIT: begin n_shift = {7'd0, i_data_in[0]}; n_bits = 4'd1; end
                    CMD_RBYTE: begin n_shift = 8'd0; n_bits = 4'd8; end
                    default: begin n_shift = 8'd0; n_bits = 4'd1; end
                endcase
            end
        end

        is_wr   = (n_op == CMD_WBYTE) || (n_op == CMD_WBIT);
        is_rd   = (n_op == CMD_RBYTE) || (n_op == CMD_RBIT);
        tmr_inc = n_tmr + 10'd1;

        case (n_phase)
            PH_RST_LOW: begin
                n_res.drive_enable = 1'b1;
                n_tmr = tmr_inc;
                if (tmr_inc >= i_timing.reset_low) begin
                    n_phase = PH_RST_WAIT;
                    n_tmr   = '0;
                    n_samp  = i_timing.pres_smp;
                end
            end
            PH_RST_WAIT: begin
                n_tmr = tmr_inc;
                if (tmr_inc >= PRESENCE_SPACING) begin
                    n_tmr = '0;
                    if (!i_line_level) begin
                        n_pres = 1'b1;
                    end
                    n_samp = n_samp - 7'd1;
                    if (n_samp == 7'd0) begin
                        n_res.done = 1'b1;
                    end
                end
            end
            PH_SLOT: begin
                if (n_tmr < {4'd0, i_timing.low_pulse}) begin
                    n_res.drive_enable = 1'b1;
                end else if (is_wr) begin
                    n_res.drive_enable = 1'b1;
                    n_res.drive_level  = n_shift[0];
                end else if (n_tmr == {2'd0, i_timing.sample_pt}) begin
                    n_shift = {i_line_level, n_shift[7:1]};
                end
                n_tmr = tmr_inc;
                if (tmr_inc >= {2'd0, i_timing.slot}) begin
                    n_tmr  = '0;
                    n_bits = n_bits - 4'd1;
                    if (is_wr) begin
                        n_shift = {1'b0, n_shift[7:1]};
                        if (i_timing.recovery != 6'd0) begin
                            n_phase = PH_RECOV;
                        end else if (n_bits == 4'd0) begin
                            n_res.done = 1'b1;
                        end
                    end else if (n_bits == 4'd0) begin
                        n_res.done = 1'b1;
                    end
                end
            end
            PH_RECOV: begin
                n_tmr = tmr_inc;
                if (tmr_inc >= {4'd0, i_timing.recovery}) begin
                    n_tmr = '0;
                    if (n_bits == 4'd0) begin
                        n_res.done = 1'b1;
                    end else begin
                        n_phase = PH_SLOT;
                    end
                end
            end
            default: n_phase = PH_IDLE;
        endcase

        if (n_res.done) begin
            if (is_rd) begin
                n_res.read_data = n_shift;
            end
            n_phase = PH_IDLE;
        end

        n_res.busy     = (n_phase != PH_IDLE);
        n_res.presence = n_pres;
    end

    // result register holds payload only, validity is tracked by the caller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_op    <= CMD_TICK;
            r_tmr   <= '0;
            r_bits  <= '0;
            r_shift <= '0;
            r_samp  <= '0;
            r_pres  <= 1'b0;
            r_res   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_op    <= n_op;
            r_tmr   <= n_tmr;
            r_bits  <= n_bits;
            r_shift <= n_shift;
            r_samp  <= n_samp;
            r_pres  <= n_pres;
            r_res   <= n_res;
        end
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

// ===== hw/rtl/owbm_checker.sv =====
// Port-level checks for the 1-Wire bus master, bound to the top level.
// Depends on onewire_bus_master_unit's port list.
`default_nettype none
module owbm_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic       o_drive_enable,
    input wire logic       o_drive_level,
    input wire logic       o_busy_res,
    input wire logic       o_done_res,
    input wire logic [7:0] o_read_data
);

    // a high level is only ever driven, never left floating
    a_level_needs_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drive_level |-> o_drive_enable)
        else $error("drive level high while released");

    // finishing an operation leaves the block idle
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done beat still busy");

    // read data appears only on the finishing beat
    a_data_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_read_data != 8'd0) |-> o_done_res)
        else $error("read data outside done beat");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_data)
            && $stable(o_done_res) && $stable(o_drive_enable))
        else $error("result changed under stall");

endmodule

bind onewire_bus_master_unit owbm_checker u_owbm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_drive_enable (o_drive_enable),
    .o_drive_level  (o_drive_level),
    .o_busy_res     (o_busy_res),
    .o_done_res     (o_done_res),
    .o_read_data    (o_read_data)
);
`default_nettype wire

// ===== bench/tb_onewire_bus_master_unit.sv =====
// Self-checking testbench for the 1-Wire bus master: directed tests, then random traffic.
// Depends on owbm_pkg and onewire_bus_master_unit; runs a line-timing predictor in step.
`timescale 1ns / 100ps
module tb_onewire_bus_master_unit;
    import owbm_pkg::*;

    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned WATCHDOG_LIMIT = 1000;

    // codes outside the command set, taken as plain ticks
    localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    typedef enum logic [2:0] {
        LN_IDLE,
        LN_RST_LOW,
        LN_RST_WAIT,
        LN_SLOT,
        LN_RECOV
    } t_line_phase;

    logic                  i_clk;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [2:0]            in_cmd    = CMD_TICK;
    logic [7:0]            in_data   = 8'h00;
    logic                  in_line   = 1'b1;
    logic                  out_ready = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = REG_LOW_PULSE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_drive_enable;
    logic       o_drive_level;
    logic       o_busy_res;
    logic       o_done_res;
    logic       o_presence;
    logic [7:0] o_read_data;
    logic       o_cmd_rejected;

    // predictor copy of the timing registers and sequencer state
    logic [5:0]       cfg_low_pulse = 6'd3;
    logic [6:0]       cfg_sample_pt = 7'd12;
    logic [7:0]       cfg_slot      = 8'd78;
    logic [5:0]       cfg_recovery  = 6'd6;
    logic [TMR_W-1:0] cfg_reset_low = 10'd520;
    logic [6:0]       cfg_pres_smp  = 7'd65;

    t_line_phase      mdl_phase    = LN_IDLE;
    logic [2:0]       mdl_op       = CMD_TICK;
    logic [TMR_W-1:0] mdl_timer    = '0;
    logic [3:0]       mdl_bits     = '0;
    logic [7:0]       mdl_shift    = '0;
    logic [6:0]       mdl_samples  = '0;
    logic             mdl_presence = 1'b0;

    t_res        line_results_due[$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;
    bit          tx_gap_en      = 1'b1;
    bit          rx_stall_en    = 1'b1;

    onewire_bus_master_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (in_cmd),
        .i_data_in      (in_data),
        .i_line_level   (in_line),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_drive_enable (o_drive_enable),
        .o_drive_level  (o_drive_level),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_presence     (o_presence),
        .o_read_data    (o_read_data),
        .o_cmd_rejected (o_cmd_rejected),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit op_is_write(input logic [2:0] op);
        return op == CMD_WBYTE || op == CMD_WBIT;
    endfunction

    function automatic bit op_is_read(input logic [2:0] op);
        return op == CMD_RBYTE || op == CMD_RBIT;
    endfunction

    // Advance the sequencer by one tick and return the line drive and status for it.
    function automatic t_res bus_master_step(input logic [2:0] cmd, input logic [7:0] din,
                                             input logic line);
        t_res        res;
        int unsigned lp, sl, sp, rl, ps;
        bit          is_cmd;
        bit          done;
        res    = '0;
        done   = 1'b0;
        is_cmd = cmd >= CMD_RESET && cmd <= CMD_RBIT;
        lp = (cfg_low_pulse != 0) ? cfg_low_pulse : 1;
        sl = (cfg_slot > lp) ? cfg_slot : lp + 1;
        sp = 32'(cfg_sample_pt);
        if (sp < lp) sp = lp;
        if (sp > sl - 1) sp = sl - 1;
        rl = (cfg_reset_low != 0) ? cfg_reset_low : 1;
        ps = (cfg_pres_smp != 0) ? cfg_pres_smp : 1;

        if (mdl_phase != LN_IDLE) begin
            if (is_cmd) res.cmd_rejected = 1'b1;
        end else if (is_cmd) begin
            mdl_op    = cmd;
            mdl_timer = '0;
            if (cmd == CMD_RESET) begin
                mdl_phase    = LN_RST_LOW;
                mdl_presence = 1'b0;
            end else begin
                mdl_phase = LN_SLOT;
                case (cmd)
                    CMD_WBYTE: begin mdl_shift = din;            mdl_bits = 4'd8; end
                    CMD_WBIT:  begin mdl_shift = {7'd0, din[0]}; mdl_bits = 4'd1; end
                    CMD_RBYTE: begin mdl_shift = 8'd0;           mdl_bits = 4'd8; end
                    default:   begin mdl_shift = 8'd0;           mdl_bits = 4'd1; end
                endcase
            end
        end

        case (mdl_phase)
            LN_RST_LOW: begin
                res.drive_enable = 1'b1;
                mdl_timer = mdl_timer + 1'b1;
                if (mdl_timer >= rl) begin
                    mdl_phase   = LN_RST_WAIT;
                    mdl_timer   = '0;
                    mdl_samples = ps[6:0];
                end
            end
            LN_RST_WAIT: begin
                mdl_timer = mdl_timer + 1'b1;
                if (mdl_timer >= PRESENCE_SPACING) begin
                    mdl_timer = '0;
                    if (!line) mdl_presence = 1'b1;
                    mdl_samples = mdl_samples - 1'b1;
                    if (mdl_samples == 0) done = 1'b1;
                end
            end
            LN_SLOT: begin
                if (mdl_timer < lp) begin
                    res.drive_enable = 1'b1;
                end else if (op_is_write(mdl_op)) begin
                    res.drive_enable = 1'b1;
                    res.drive_level  = mdl_shift[0];
                end else if (mdl_timer == sp) begin
                    mdl_shift = {line, mdl_shift[7:1]};
                end
                mdl_timer = mdl_timer + 1'b1;
                if (mdl_timer >= sl) begin
                    mdl_timer = '0;
                    mdl_bits  = mdl_bits - 1'b1;
                    if (op_is_write(mdl_op)) begin
                        mdl_shift = mdl_shift >> 1;
                        if (cfg_recovery != 0) mdl_phase = LN_RECOV;
                        else if (mdl_bits == 0) done = 1'b1;
                    end else if (mdl_bits == 0) begin
                        done = 1'b1;
                    end
                end
            end
            LN_RECOV: begin
                mdl_timer = mdl_timer + 1'b1;
                if (mdl_timer >= cfg_recovery) begin
                    mdl_timer = '0;
                    if (mdl_bits == 0) done = 1'b1;
                    else mdl_phase = LN_SLOT;
                end
            end
            default: begin
                mdl_phase = LN_IDLE;
            end
        endcase

        if (done) begin
            if (op_is_read(mdl_op)) res.read_data = mdl_shift;
            mdl_phase = LN_IDLE;
        end
        res.busy     = mdl_phase != LN_IDLE;
        res.done     = done;
        res.presence = mdl_presence;
        return res;
    endfunction

    // Offer one beat, hold it until accepted, then record what it must produce.
    task automatic send_beat(input logic [2:0] cmd, input logic [7:0] din, input logic line);
        int unsigned gap;
        gap = tx_gap_en ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_cmd   <= cmd;
        in_data  <= din;
        in_line  <= line;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        line_results_due.push_back(bus_master_step(cmd, din, line));
    endtask

    // Tick until the running operation ends; line either random or held high.
    task automatic run_until_idle(input bit line_rand);
        while (mdl_phase != LN_IDLE) begin
            send_beat(CMD_TICK, 8'($urandom_range(0, 255)),
                      line_rand ? 1'($urandom_range(0, 1)) : 1'b1);
        end
    endtask

    // Hold the sender until every result is back, then let the pipeline settle.
    task automatic wait_results_idle();
        in_valid <= 1'b0;
        while (line_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_timing(input logic [5:0] lp, input logic [6:0] sp, input logic [7:0] sl,
                                input logic [5:0] rc, input logic [9:0] rl,
                                input logic [6:0] ps);
        run_until_idle(1'b1);
        wait_results_idle();
        write_reg(REG_LOW_PULSE, CFG_DATA_W'(lp));
        write_reg(REG_SAMPLE_PT, CFG_DATA_W'(sp));
        write_reg(REG_SLOT,      CFG_DATA_W'(sl));
        write_reg(REG_RECOVERY,  CFG_DATA_W'(rc));
        write_reg(REG_RESET_LOW, CFG_DATA_W'(rl));
        write_reg(REG_PRES_SMP,  CFG_DATA_W'(ps));
        cfg_we <= 1'b0;
        cfg_low_pulse = lp;
        cfg_sample_pt = sp;
        cfg_slot      = sl;
        cfg_recovery  = rc;
        cfg_reset_low = rl;
        cfg_pres_smp  = ps;
    endtask

    task automatic test_power_up_timing();
        // one read slot on the register values left by reset
        send_beat(CMD_RBIT, 8'h00, 1'b1);
        run_until_idle(1'b1);
    endtask

    task automatic test_reset_pulse();
        // no device on the line first, then a device pulling low now and then
        apply_timing(6'd2, 7'd4, 8'd5, 6'd1, 10'd2, 7'd2);
        send_beat(CMD_RESET, 8'h00, 1'b1);
        run_until_idle(1'b0);
        send_beat(CMD_RESET, 8'hFF, 1'b0);
        run_until_idle(1'b1);
    endtask

    task automatic test_write_slots();
        apply_timing(6'd1, 7'd2, 8'd3, 6'd1, 10'd2, 7'd2);
        send_beat(CMD_WBYTE, 8'hA5, 1'b1);
        run_until_idle(1'b1);
        send_beat(CMD_WBIT, 8'hFE, 1'b0);
        run_until_idle(1'b1);
        // no recovery between slots
        apply_timing(6'd1, 7'd1, 8'd3, 6'd0, 10'd2, 7'd2);
        send_beat(CMD_WBYTE, 8'h6C, 1'b0);
        run_until_idle(1'b1);
    endtask

    task automatic test_read_slots();
        apply_timing(6'd1, 7'd2, 8'd4, 6'd1, 10'd2, 7'd2);
        send_beat(CMD_RBYTE, 8'h5A, 1'b0);
        run_until_idle(1'b1);
        send_beat(CMD_RBIT, 8'hFF, 1'b1);
        run_until_idle(1'b1);
    endtask

    task automatic test_timing_clamps();
        // all-zero registers: every time taken as its minimum
        apply_timing(6'd0, 7'd0, 8'd0, 6'd0, 10'd0, 7'd0);
        send_beat(CMD_RESET, 8'h00, 1'b0);
        run_until_idle(1'b1);
        send_beat(CMD_WBYTE, 8'hFF, 1'b1);
        run_until_idle(1'b1);
        send_beat(CMD_RBIT, 8'h00, 1'b0);
        run_until_idle(1'b1);
        // sample point inside the low pulse
        apply_timing(6'd5, 7'd2, 8'd7, 6'd2, 10'd3, 7'd2);
        send_beat(CMD_RBIT, 8'h00, 1'b1);
        run_until_idle(1'b1);
        // sample point past the end of the slot
        apply_timing(6'd3, 7'd100, 8'd5, 6'd1, 10'd3, 7'd2);
        send_beat(CMD_RBIT, 8'h00, 1'b0);
        run_until_idle(1'b1);
        // slot no longer than the low pulse, no recovery
        apply_timing(6'd6, 7'd4, 8'd6, 6'd0, 10'd2, 7'd1);
        send_beat(CMD_WBIT, 8'h01, 1'b1);
        run_until_idle(1'b1);
        send_beat(CMD_RBIT, 8'h00, 1'b1);
        run_until_idle(1'b1);
        // low pulse and sample point at their top values
        apply_timing(6'd63, 7'd127, 8'd8, 6'd63, 10'd1, 7'd1);
        send_beat(CMD_RBIT, 8'h00, 1'b1);
        run_until_idle(1'b1);
    endtask

    task automatic test_busy_commands();
        apply_timing(6'd1, 7'd2, 8'd3, 6'd1, 10'd2, 7'd2);
        send_beat(CMD_WBYTE, 8'h3C, 1'b1);
        for (int c = CMD_RESET; c <= CMD_UNUSED_HI; c++) begin
            send_beat(c[2:0], 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        run_until_idle(1'b1);
        // unknown codes from idle start nothing
        send_beat(CMD_UNUSED_LO, 8'hFF, 1'b0);
        send_beat(CMD_UNUSED_HI, 8'h00, 1'b1);
        send_beat(CMD_RESET, 8'h00, 1'b1);
        send_beat(CMD_RBIT, 8'h00, 1'b0);
        run_until_idle(1'b1);
    endtask

    task automatic test_random_traffic();
        logic [2:0]  cmd;
        int unsigned roll;
        for (int seg = 0; seg < 3; seg++) begin
            tx_gap_en   = (seg != 2) && ($urandom_range(0, 3) != 0);
            rx_stall_en = (seg != 2) && ($urandom_range(0, 3) != 0);
            apply_timing(6'($urandom_range(0, 4)), 7'($urandom_range(0, 12)),
                         8'($urandom_range(0, 12)), 6'($urandom_range(0, 3)),
                         10'($urandom_range(0, 12)), 7'($urandom_range(0, 4)));
            for (int i = 0; i < 30; i++) begin
                roll = $urandom_range(0, 99);
                if (mdl_phase == LN_IDLE) begin
                    if (roll < 80) begin
                        cmd = 3'($urandom_range(CMD_RESET, CMD_RBIT));
                    end else begin
                        case ($urandom_range(0, 2))
                            0:       cmd = CMD_TICK;
                            1:       cmd = CMD_UNUSED_LO;
                            default: cmd = CMD_UNUSED_HI;
                        endcase
                    end
                end else begin
                    // mostly ticks, a few stray commands to be rejected
                    cmd = (roll < 88) ? CMD_TICK
                                      : 3'($urandom_range(CMD_RESET, CMD_UNUSED_HI));
                end
                send_beat(cmd, 8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0);
                if (seg == 1 && i == 15) wait_results_idle();
            end
        end
        run_until_idle(1'b1);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_power_up_timing();
        test_reset_pulse();
        test_write_slots();
        test_read_slots();
        test_timing_clamps();
        test_busy_commands();
        test_random_traffic();
        wait_results_idle();
        if (mismatch_count == 0 && line_results_due.size() == 0) begin
            $display("onewire_bus_master_unit regression: pass");
        end else begin
            $display("onewire_bus_master_unit regression: fail");
        end
        $finish;
    end

    // Receiver: draw a stall for every result, then hold ready until the beat goes.
    initial begin
        int unsigned stall;
        forever begin
            stall = rx_stall_en ? $urandom_range(0, 6) : 0;
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!(o_out_valid && i_rst_n)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_res exp_res;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (line_results_due.size() == 0) begin
                $error("result beat with nothing expected");
                mismatch_count++;
            end else begin
                exp_res = line_results_due.pop_front();
                if (o_drive_enable !== exp_res.drive_enable) begin
                    $error("drive_enable: expected %0d, got %0d",
                           exp_res.drive_enable, o_drive_enable);
                    mismatch_count++;
                end
                if (o_drive_level !== exp_res.drive_level) begin
                    $error("drive_level: expected %0d, got %0d",
                           exp_res.drive_level, o_drive_level);
                    mismatch_count++;
                end
                if (o_busy_res !== exp_res.busy) begin
                    $error("busy_res: expected %0d, got %0d", exp_res.busy, o_busy_res);
                    mismatch_count++;
                end
                if (o_done_res !== exp_res.done) begin
                    $error("done_res: expected %0d, got %0d", exp_res.done, o_done_res);
                    mismatch_count++;
                end
                if (o_presence !== exp_res.presence) begin
                    $error("presence: expected %0d, got %0d", exp_res.presence, o_presence);
                    mismatch_count++;
                end
                if (o_read_data !== exp_res.read_data) begin
                    $error("read_data: expected 0x%02h, got 0x%02h",
                           exp_res.read_data, o_read_data);
                    mismatch_count++;
                end
                if (o_cmd_rejected !== exp_res.cmd_rejected) begin
                    $error("cmd_rejected: expected %0d, got %0d",
                           exp_res.cmd_rejected, o_cmd_rejected);
                    mismatch_count++;
                end
            end
        end
    end

    // count cycles in which neither channel moves a beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("onewire_bus_master_unit regression: fail");
        $finish;
    end

endmodule
